FILE: rtl/core/vgc_pkg.sv
// ----------------------------------------------------------------------------
// vgc_pkg
// Shared types and constants of the voice gated capture block: opcodes,
// end reasons, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package vgc_pkg;

	// Capture buffer and block sizing
	localparam int RECORD_CAPACITY = 262144;
	localparam int BLOCK_MAX       = 256;

	localparam int OP_W     = 2;
	localparam int SMP_W    = 16;
	localparam int MAG_W    = SMP_W + 1;
	localparam int REC_W    = 19;
	localparam int ADDR_W   = 18;
	localparam int QT_W     = 15;
	localparam int BLK_W    = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W    = QT_W + BLK_W;
	localparam int TRI_W    = BLK_W + 2;
	localparam int REASON_W = 2;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 19;

	typedef logic [OP_W-1:0]     opcode_t;
	typedef logic [REASON_W-1:0] reason_t;
	typedef logic [IDX_W-1:0]    cfg_idx_t;

	// Opcodes
	localparam opcode_t OP_SAMPLE = 2'd0;
	localparam opcode_t OP_START  = 2'd1;
	localparam opcode_t OP_CANCEL = 2'd2;
	localparam opcode_t OP_STOP   = 2'd3;

	// End reasons
	localparam reason_t END_LENGTH    = 2'd0;
	localparam reason_t END_HALT      = 2'd1;
	localparam reason_t END_SILENCE   = 2'd2;
	localparam reason_t END_NO_SPEECH = 2'd3;

	// Register indexes
	localparam cfg_idx_t REG_CUTOFF_ENABLE   = 3'd0;
	localparam cfg_idx_t REG_MAX_FRAMES      = 3'd1;
	localparam cfg_idx_t REG_QUIET_THRESHOLD = 3'd2;
	localparam cfg_idx_t REG_SILENCE_LIMIT   = 3'd3;
	localparam cfg_idx_t REG_SPEECH_MINIMUM  = 3'd4;
	localparam cfg_idx_t REG_NO_SPEECH_LIMIT = 3'd5;

	// Register reset values
	localparam logic [REC_W-1:0] MAX_FRAMES_RST      = 19'd262144;
	localparam logic [QT_W-1:0]  QUIET_THRESHOLD_RST = 15'd400;
	localparam logic [REC_W-1:0] SILENCE_LIMIT_RST   = 19'd12800;
	localparam logic [REC_W-1:0] SPEECH_MINIMUM_RST  = 19'd4000;
	localparam logic [REC_W-1:0] NO_SPEECH_LIMIT_RST = 19'd48000;

	localparam logic [REC_W-1:0] CAPACITY  = REC_W'(RECORD_CAPACITY);
	localparam logic [REC_W-1:0] COUNT_SAT = {REC_W{1'b1}};
	localparam logic [BLK_W-1:0] BLOCK_LEN = BLK_W'(BLOCK_MAX);

	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

endpackage

FILE: rtl/core/voice_gated_capture_top.sv
// ----------------------------------------------------------------------------
// voice_gated_capture_top
// Energy gated microphone capture: passes captured samples on with buffer
// addresses and ends the capture on length, request, silence or no speech.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle as long as results are taken. A
// request is registered on accept in the input register, evaluated from
// there against the capture state, and its result (if any) is loaded into
// the output register, so the block sustains one request per cycle as long
// as results are taken. Only a sample taken while capturing, or a start
// with a zero length limit, produces a result; cancel and stop requests
// are recorded and acted on at the next block end. The block quiet test
// is a 15 x 9 bit multiply of threshold by block length compared against
// the block's absolute sum; that multiply and compare sets the cycle time.
// Configuration registers are read live and may be written only when no
// request is in flight.
module voice_gated_capture_top
	import vgc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_wr_en,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,

	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [OP_W-1:0]         opcode,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    block_end,

	output logic                    result_valid,
	input  logic                    result_ready,
	output logic                    store_valid,
	output logic [ADDR_W-1:0]       store_address,
	output logic signed [SMP_W-1:0] stored_sample,
	output logic                    done_res,
	output logic [REASON_W-1:0]     end_reason,
	output logic [REC_W-1:0]        frames_recorded,
	output logic [REC_W-1:0]        speech_total,
	output logic signed [SMP_W-1:0] min_sample,
	output logic signed [SMP_W-1:0] max_sample,
	output logic                    cancelled
);

	// Configuration
	logic             cutoff_enable_q;
	logic [REC_W-1:0] max_frames_q;
	logic [QT_W-1:0]  quiet_threshold_q;
	logic [REC_W-1:0] silence_limit_q;
	logic [REC_W-1:0] speech_minimum_q;
	logic [REC_W-1:0] no_speech_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_enable_q   <= 1'b1;
			max_frames_q      <= MAX_FRAMES_RST;
			quiet_threshold_q <= QUIET_THRESHOLD_RST;
			silence_limit_q   <= SILENCE_LIMIT_RST;
			speech_minimum_q  <= SPEECH_MINIMUM_RST;
			no_speech_limit_q <= NO_SPEECH_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CUTOFF_ENABLE:   cutoff_enable_q   <= cfg_wdata[0];
				REG_MAX_FRAMES:      max_frames_q      <= cfg_wdata[REC_W-1:0];
				REG_QUIET_THRESHOLD: quiet_threshold_q <= cfg_wdata[QT_W-1:0];
				REG_SILENCE_LIMIT:   silence_limit_q   <= cfg_wdata[REC_W-1:0];
				REG_SPEECH_MINIMUM:  speech_minimum_q  <= cfg_wdata[REC_W-1:0];
				REG_NO_SPEECH_LIMIT: no_speech_limit_q <= cfg_wdata[REC_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic                    valid_s1;
	opcode_t                 op_s1;
	logic signed [SMP_W-1:0] sample_s1;
	logic                    bend_s1;
	logic [MAG_W-1:0]        mag_s1;
	logic                    fire_s1;
	logic                    has_res;

	assign item_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Take the magnitude at the input so the block sum is a plain add later
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1     <= opcode;
			sample_s1 <= sample;
			bend_s1   <= block_end;
			mag_s1    <= sample[SMP_W-1] ? MAG_W'(-{sample[SMP_W-1], sample})
			                             : MAG_W'({1'b0, sample});
		end
	end

	// Capture state
	logic                    capturing_q;
	logic [REC_W-1:0]        recorded_count_q;
	logic [BLK_W-1:0]        block_count_q;
	logic [SUM_W-1:0]        block_abs_sum_q;
	logic [REC_W-1:0]        speech_count_q;
	logic [REC_W-1:0]        silence_count_q;
	logic signed [SMP_W-1:0] running_min_q;
	logic signed [SMP_W-1:0] running_max_q;
	logic                    cancel_pending_q;
	logic                    stop_pending_q;

	logic                    capturing_nx;
	logic [REC_W-1:0]        recorded_count_nx;
	logic [BLK_W-1:0]        block_count_nx;
	logic [SUM_W-1:0]        block_abs_sum_nx;
	logic [REC_W-1:0]        speech_count_nx;
	logic [REC_W-1:0]        silence_count_nx;
	logic signed [SMP_W-1:0] running_min_nx;
	logic signed [SMP_W-1:0] running_max_nx;
	logic                    cancel_pending_nx;
	logic                    stop_pending_nx;

	// Per-sample arithmetic
	logic [REC_W-1:0] limit;
	logic [REC_W-1:0] rec_inc;
	logic [BLK_W-1:0] blk_inc;
	logic [SUM_W-1:0] sum_inc;
	logic [SUM_W-1:0] quiet_bound;
	logic             quiet;
	logic [REC_W:0]   sil_add;
	logic [REC_W:0]   spc_add;
	logic [REC_W-1:0] sil_sat;
	logic [REC_W-1:0] spc_sat;
	logic [TRI_W-1:0] tri_len;
	logic [REC_W-1:0] sil_sub;
	logic             blk_done;

	assign limit   = (max_frames_q > CAPACITY) ? CAPACITY : max_frames_q;
	assign rec_inc = (recorded_count_q < COUNT_SAT) ? recorded_count_q + 1'b1
	                                                : recorded_count_q;
	assign blk_inc = block_count_q + 1'b1;
	assign sum_inc = block_abs_sum_q + SUM_W'(mag_s1);
	assign quiet_bound = SUM_W'(quiet_threshold_q) * SUM_W'(blk_inc);
	assign quiet   = sum_inc < quiet_bound;

	assign sil_add = {1'b0, silence_count_q} + (REC_W+1)'(blk_inc);
	assign spc_add = {1'b0, speech_count_q} + (REC_W+1)'(blk_inc);
	assign sil_sat = sil_add[REC_W] ? COUNT_SAT : sil_add[REC_W-1:0];
	assign spc_sat = spc_add[REC_W] ? COUNT_SAT : spc_add[REC_W-1:0];
	assign tri_len = {blk_inc, 1'b0} + TRI_W'(blk_inc);
	assign sil_sub = (silence_count_q > REC_W'(tri_len)) ?
	                 silence_count_q - REC_W'(tri_len) : '0;

	assign blk_done = bend_s1 || (blk_inc >= BLOCK_LEN) || (rec_inc >= limit);

	assign has_res = valid_s1 && (((op_s1 == OP_SAMPLE) && capturing_q) ||
	                 ((op_s1 == OP_START) && !capturing_q && (limit == '0)));
	assign fire_s1 = valid_s1 && (!has_res || !result_valid || result_ready);

	// Result fields
	logic                    res_store;
	logic [ADDR_W-1:0]       res_addr;
	logic signed [SMP_W-1:0] res_sample;
	logic                    fin;
	reason_t                 reason;

	always_comb begin
		capturing_nx      = capturing_q;
		recorded_count_nx = recorded_count_q;
		block_count_nx    = block_count_q;
		block_abs_sum_nx  = block_abs_sum_q;
		speech_count_nx   = speech_count_q;
		silence_count_nx  = silence_count_q;
		running_min_nx    = running_min_q;
		running_max_nx    = running_max_q;
		cancel_pending_nx = cancel_pending_q;
		stop_pending_nx   = stop_pending_q;
		res_store         = 1'b0;
		res_addr          = '0;
		res_sample        = '0;
		fin               = 1'b0;
		reason            = END_LENGTH;

		unique case (op_s1)
			OP_CANCEL: cancel_pending_nx = 1'b1;
			OP_STOP:   stop_pending_nx   = 1'b1;
			OP_START: begin
				if (!capturing_q) begin
					capturing_nx      = 1'b1;
					recorded_count_nx = '0;
					block_count_nx    = '0;
					block_abs_sum_nx  = '0;
					speech_count_nx   = '0;
					silence_count_nx  = '0;
					running_min_nx    = SMP_MAX;
					running_max_nx    = SMP_MIN;
					cancel_pending_nx = 1'b0;
					fin               = (limit == '0);
				end
			end
			OP_SAMPLE: begin
				if (capturing_q) begin
					res_store         = 1'b1;
					res_addr          = recorded_count_q[ADDR_W-1:0];
					res_sample        = sample_s1;
					recorded_count_nx = rec_inc;
					if (sample_s1 < running_min_q) running_min_nx = sample_s1;
					if (sample_s1 > running_max_q) running_max_nx = sample_s1;
					if (blk_done) begin
						block_count_nx   = '0;
						block_abs_sum_nx = '0;
						if (cancel_pending_q || stop_pending_q) begin
							fin    = 1'b1;
							reason = END_HALT;
						end else if (cutoff_enable_q) begin
							if (quiet) begin
								silence_count_nx = sil_sat;
								if ((speech_count_q >= speech_minimum_q) &&
								    (sil_sat > silence_limit_q)) begin
									fin    = 1'b1;
									reason = END_SILENCE;
								end else if ((speech_count_q < speech_minimum_q) &&
								             (rec_inc > no_speech_limit_q)) begin
									fin    = 1'b1;
									reason = END_NO_SPEECH;
								end
							end else begin
								speech_count_nx  = spc_sat;
								silence_count_nx = sil_sub;
							end
						end
						if (!fin && (rec_inc >= limit)) begin
							fin    = 1'b1;
							reason = END_LENGTH;
						end
					end else begin
						block_count_nx   = blk_inc;
						block_abs_sum_nx = sum_inc;
					end
				end
			end
			default: ;
		endcase

		// Report fields are taken before the end of capture clears the flags
		if (fin) begin
			capturing_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q      <= 1'b0;
			recorded_count_q <= '0;
			block_count_q    <= '0;
			block_abs_sum_q  <= '0;
			speech_count_q   <= '0;
			silence_count_q  <= '0;
			running_min_q    <= SMP_MAX;
			running_max_q    <= SMP_MIN;
			cancel_pending_q <= 1'b0;
			stop_pending_q   <= 1'b0;
		end else if (fire_s1) begin
			capturing_q      <= capturing_nx;
			recorded_count_q <= recorded_count_nx;
			block_count_q    <= block_count_nx;
			block_abs_sum_q  <= block_abs_sum_nx;
			speech_count_q   <= speech_count_nx;
			silence_count_q  <= silence_count_nx;
			running_min_q    <= running_min_nx;
			running_max_q    <= running_max_nx;
			cancel_pending_q <= fin ? 1'b0 : cancel_pending_nx;
			stop_pending_q   <= fin ? 1'b0 : stop_pending_nx;
		end
	end

	// Output register
	logic result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && has_res) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_res) begin
			store_valid     <= res_store;
			store_address   <= res_addr;
			stored_sample   <= res_sample;
			done_res        <= fin;
			end_reason      <= fin ? reason : END_LENGTH;
			frames_recorded <= fin ? recorded_count_nx : '0;
			speech_total    <= fin ? speech_count_nx : '0;
			min_sample      <= fin ? running_min_nx : '0;
			max_sample      <= fin ? running_max_nx : '0;
			cancelled       <= fin && cancel_pending_nx;
		end
	end

	assign result_valid = result_valid_q;

	// Checks
	a_nostore_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !store_valid |-> done_res)
		else $error("result without store must end the capture");

	a_cancel_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cancelled |-> done_res && (end_reason == END_HALT))
		else $error("cancelled capture must report a request end");

	a_minmax_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_res && (frames_recorded != '0) |->
		(min_sample <= max_sample))
		else $error("reported minimum above maximum");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && fin |=> !capturing_q && !cancel_pending_q && !stop_pending_q)
		else $error("capture state not cleared after end");

endmodule
